FILE: sv/glpe_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the GIF LZW pixel encoder.
// No dependencies; glpe_packer and gif_lzw_pixel_encoder import this package.
package glpe_pkg;

   localparam int TABLE_SLOTS    = 8192;
   localparam int MAX_CODE_WIDTH = 12;
   localparam int HASH_MOD       = 5003;
   localparam int PROBE_STEP     = 15;
   localparam int MOD_USED       = (TABLE_SLOTS < HASH_MOD) ? TABLE_SLOTS : HASH_MOD;
   localparam int ADDR_W         = $clog2(TABLE_SLOTS);
   localparam int EPOCH_W        = 4;
   localparam int CODE_W         = 12;
   localparam int KEY_W          = 20;
   localparam int WIDTH_W        = 4;
   localparam int CSR_W          = 4;
   localparam int CNT_W          = 13;
   localparam int WORD_W         = EPOCH_W + KEY_W + CODE_W;

   // One code handed to the bit packer.
   typedef struct packed {
      logic                 valid;
      logic [CODE_W-1:0]    code;
      logic [WIDTH_W-1:0]   width;
      logic                 last_code;
   } glpe_cmd_type;

endpackage

FILE: sv/glpe_req_if.sv
`timescale 1ns / 1ps
// Pixel input channel: valid/ready handshake with pixel payload.
// No dependencies.
interface glpe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;
   logic       last_pixel;
   modport source (output valid, pixel, last_pixel, input ready);
   modport sink   (input valid, pixel, last_pixel, output ready);
endinterface

FILE: sv/glpe_rsp_if.sv
`timescale 1ns / 1ps
// Byte output channel: valid/ready handshake with stream byte payload.
// No dependencies.
interface glpe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       end_of_image;
   modport source (output valid, out_byte, end_of_image, input ready);
   modport sink   (input valid, out_byte, end_of_image, output ready);
endinterface

FILE: sv/glpe_csr_if.sv
`timescale 1ns / 1ps
// Configuration write channel carrying min_code_size.
// No dependencies.
interface glpe_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] min_code_size;
   modport source (output valid, min_code_size, input ready);
   modport sink   (input valid, min_code_size, output ready);
endinterface

FILE: sv/glpe_packer.sv
`timescale 1ns / 1ps
// LSB-first bit packer: takes one code per handshake, gives bytes.
// Depends on glpe_pkg and glpe_rsp_if.
module glpe_packer
   import glpe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  glpe_cmd_type  cmd,
   output logic          cmd_ready,
   glpe_rsp_if.source    rsp_ch
);

   logic [23:0] acc_ff, acc_in;
   logic [4:0]  pend_ff, pend_in;
   logic        fin_ff, fin_in;
   logic        ovalid_ff, ovalid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        eoi_ff, eoi_in;

   logic        have_byte, can_load;
   logic [12:0] mask;
   logic [23:0] bits;

   assign cmd_ready = (pend_ff < 5'd8) && !fin_ff;
   assign have_byte = (pend_ff >= 5'd8) || (fin_ff && (pend_ff != 5'd0));
   assign can_load  = !ovalid_ff || rsp_ch.ready;

   always_comb begin
      mask      = (13'd1 << cmd.width) - 13'd1;
      bits      = 24'({1'b0, cmd.code} & mask) << pend_ff[2:0];
      acc_in    = acc_ff;
      pend_in   = pend_ff;
      fin_in    = fin_ff;
      ovalid_in = ovalid_ff;
      byte_in   = byte_ff;
      eoi_in    = eoi_ff;
      if (rsp_ch.ready) begin
         ovalid_in = 1'b0;
      end
      if (cmd.valid && cmd_ready) begin
         acc_in  = acc_ff | bits;
         pend_in = pend_ff + 5'(cmd.width);
         fin_in  = cmd.last_code;
      end else if (have_byte && can_load) begin
         ovalid_in = 1'b1;
         byte_in   = acc_ff[7:0];
         acc_in    = acc_ff >> 8;
         eoi_in    = fin_ff && (pend_ff <= 5'd8);
         pend_in   = (pend_ff >= 5'd8) ? pend_ff - 5'd8 : 5'd0;
         if (eoi_in) begin
            // pad with zeros and close the image
            fin_in  = 1'b0;
            acc_in  = '0;
            pend_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         pend_ff   <= '0;
         fin_ff    <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         pend_ff   <= pend_in;
         fin_ff    <= fin_in;
         ovalid_ff <= ovalid_in;
      end
      byte_ff <= byte_in;
      eoi_ff  <= eoi_in;
   end

   assign rsp_ch.valid        = ovalid_ff;
   assign rsp_ch.out_byte     = byte_ff;
   assign rsp_ch.end_of_image = eoi_ff;

endmodule

FILE: sv/gif_lzw_pixel_encoder.sv
`timescale 1ns / 1ps
// GIF LZW pixel encoder: one pixel at a time, dictionary in a hashed memory.
// Each pixel is accepted, then read and compared; each extra probe repeats the read
// and the compare. A miss then hands codes to the bit packer (up to 4), which drains
// each full byte before it takes the next code; the first pixel of an image is
// accept plus two codes. Bytes then leave one per cycle while the output is ready.
// Throughput is set by the dictionary read loop and the packer drain.
// Reset (synchronous) sweeps all TABLE_SLOTS entries, one per cycle, before the
// first pixel; the same sweep runs again each time the 4-bit epoch wraps.
module gif_lzw_pixel_encoder
   import glpe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   glpe_req_if.sink   req_ch,
   glpe_rsp_if.source rsp_ch,
   glpe_csr_if.sink   csr_ch
);

   typedef enum logic [3:0] {
      S_SWEEP, S_IDLE, S_START_CS, S_START_CLR, S_READ, S_CHECK,
      S_MISS_EMIT, S_MISS_CLR, S_LAST_CODE, S_LAST_CLR, S_LAST_EOI
   } state_type;

   // Dictionary memory: {epoch, key, code}; an entry is valid when its epoch
   // matches the current one, so a dictionary reset is just an epoch bump.
   logic [WORD_W-1:0] mem [TABLE_SLOTS];
   logic [WORD_W-1:0] rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [WORD_W-1:0] mem_wd;
   logic              mem_re;

   state_type          state_ff, state_in;
   logic [CSR_W-1:0]   csr_ff;
   logic [7:0]         px_ff, px_in;
   logic               last_ff, last_in;
   logic [CODE_W-1:0]  prefix_ff, prefix_in;
   logic [CNT_W-1:0]   nfc_ff, nfc_in;
   logic [CNT_W-1:0]   thr_ff, thr_in;
   logic [WIDTH_W-1:0] cw_ff, cw_in;
   logic               started_ff, started_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic               sweep_req_ff, sweep_req_in;

   glpe_cmd_type       cmd;
   logic               cmd_ready, cmd_fire;

   logic [3:0]         cs_eff;
   logic [WIDTH_W-1:0] base_width;
   logic [CODE_W-1:0]  clear_code, eoi_code;
   logic [CNT_W-1:0]   dict_nfc, dict_thr, nfc_next, thr_dbl;
   logic [7:0]         px_masked;
   logic [KEY_W-1:0]   key;
   logic [ADDR_W:0]    probe_sum;
   logic [ADDR_W-1:0]  probe_addr;
   logic               entry_valid;
   logic [EPOCH_W-1:0] rd_epoch;
   logic [KEY_W-1:0]   rd_key;
   logic [CODE_W-1:0]  rd_code;

   glpe_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .rsp_ch    (rsp_ch)
   );

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = (state_ff == S_IDLE);

   // Clamp the code size into 2..8 and derive the special codes.
   always_comb begin
      if (csr_ff < 4'd2) begin
         cs_eff = 4'd2;
      end else if (csr_ff > 4'd8) begin
         cs_eff = 4'd8;
      end else begin
         cs_eff = csr_ff;
      end
   end

   assign base_width = cs_eff + 4'd1;
   assign clear_code = CODE_W'(1) << cs_eff;
   assign eoi_code   = clear_code + CODE_W'(1);
   assign dict_nfc   = CNT_W'(eoi_code) + CNT_W'(1);
   assign dict_thr   = CNT_W'(1) << base_width;
   assign px_masked  = req_ch.pixel & clear_code[7:0] - 8'd1;
   assign key        = {prefix_ff, px_ff};
   assign nfc_next   = nfc_ff + CNT_W'(1);
   assign thr_dbl    = {thr_ff[CNT_W-2:0], 1'b0};

   assign {rd_epoch, rd_key, rd_code} = rd_data_ff;
   assign entry_valid = (rd_epoch == epoch_ff);

   // Linear probe, wrapped at the hash modulus.
   assign probe_sum  = {1'b0, addr_ff} + (ADDR_W + 1)'(PROBE_STEP);
   assign probe_addr = (probe_sum >= (ADDR_W + 1)'(MOD_USED)) ?
                       ADDR_W'(probe_sum - (ADDR_W + 1)'(MOD_USED)) : probe_sum[ADDR_W-1:0];

   // Code handed to the packer in each emit state.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_START_CS:  cmd = '{1'b1, CODE_W'(cs_eff), WIDTH_W'(8), 1'b0};
         S_START_CLR: cmd = '{1'b1, clear_code, base_width, 1'b0};
         S_MISS_EMIT: cmd = '{1'b1, prefix_ff, cw_ff, 1'b0};
         S_MISS_CLR:  cmd = '{1'b1, clear_code, cw_ff, 1'b0};
         S_LAST_CODE: cmd = '{1'b1, prefix_ff, cw_ff, 1'b0};
         S_LAST_CLR:  cmd = '{1'b1, clear_code, cw_ff, 1'b0};
         S_LAST_EOI:  cmd = '{1'b1, eoi_code, cw_ff, 1'b1};
         default:     cmd = '0;
      endcase
   end
   assign cmd_fire = cmd.valid && cmd_ready;

   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      last_in      = last_ff;
      prefix_in    = prefix_ff;
      nfc_in       = nfc_ff;
      thr_in       = thr_ff;
      cw_in        = cw_ff;
      started_in   = started_ff;
      addr_in      = addr_ff;
      sweep_in     = sweep_ff;
      epoch_in     = epoch_ff;
      sweep_req_in = sweep_req_ff;
      mem_we       = 1'b0;
      mem_wa       = addr_ff;
      mem_wd       = {epoch_ff, key, nfc_ff[CODE_W-1:0]};
      mem_re       = 1'b0;

      unique case (state_ff)
         S_SWEEP: begin
            // Clear one entry per cycle back to epoch zero.
            mem_we   = 1'b1;
            mem_wa   = sweep_ff;
            mem_wd   = '0;
            sweep_in = sweep_ff + ADDR_W'(1);
            if (sweep_ff == ADDR_W'(TABLE_SLOTS - 1)) begin
               epoch_in     = EPOCH_W'(1);
               sweep_req_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               px_in   = px_masked;
               last_in = req_ch.last_pixel;
               addr_in = ADDR_W'(prefix_ff ^ {px_masked, 4'b0});
               state_in = started_ff ? S_READ : S_START_CS;
            end
         end
         S_START_CS: begin
            if (cmd_fire) begin
               state_in = S_START_CLR;
            end
         end
         S_START_CLR: begin
            if (cmd_fire) begin
               cw_in      = base_width;
               nfc_in     = dict_nfc;
               thr_in     = dict_thr;
               prefix_in  = CODE_W'(px_ff);
               started_in = 1'b1;
               if (epoch_ff == '1) begin
                  sweep_req_in = 1'b1;
               end else begin
                  epoch_in = epoch_ff + EPOCH_W'(1);
               end
               state_in = last_ff ? S_LAST_CODE : (sweep_req_in ? S_SWEEP : S_IDLE);
            end
         end
         S_READ: begin
            mem_re   = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!entry_valid) begin
               // Empty slot: store the new string and emit the prefix.
               mem_we   = 1'b1;
               state_in = S_MISS_EMIT;
            end else if (rd_key == key) begin
               prefix_in = rd_code;
               state_in  = last_ff ? S_LAST_CODE : S_IDLE;
            end else begin
               addr_in  = probe_addr;
               state_in = S_READ;
            end
         end
         S_MISS_EMIT: begin
            if (cmd_fire) begin
               nfc_in    = nfc_next;
               prefix_in = CODE_W'(px_ff);
               state_in  = last_ff ? S_LAST_CODE : S_IDLE;
               if (nfc_next > thr_ff) begin
                  if (cw_ff >= WIDTH_W'(MAX_CODE_WIDTH)) begin
                     state_in = S_MISS_CLR;
                  end else begin
                     thr_in = (thr_dbl > CNT_W'(12'hFFF)) ? CNT_W'(12'hFFF) : thr_dbl;
                     cw_in  = cw_ff + WIDTH_W'(1);
                  end
               end
            end
         end
         S_MISS_CLR: begin
            if (cmd_fire) begin
               cw_in  = base_width;
               nfc_in = dict_nfc;
               thr_in = dict_thr;
               if (epoch_ff == '1) begin
                  sweep_req_in = 1'b1;
               end else begin
                  epoch_in = epoch_ff + EPOCH_W'(1);
               end
               state_in = last_ff ? S_LAST_CODE : (sweep_req_in ? S_SWEEP : S_IDLE);
            end
         end
         S_LAST_CODE: begin
            if (cmd_fire) begin
               state_in = S_LAST_EOI;
               if (nfc_ff == thr_ff) begin
                  if (cw_ff >= WIDTH_W'(MAX_CODE_WIDTH)) begin
                     cw_in    = base_width;
                     state_in = S_LAST_CLR;
                  end else begin
                     cw_in = cw_ff + WIDTH_W'(1);
                  end
               end
            end
         end
         S_LAST_CLR: begin
            if (cmd_fire) begin
               state_in = S_LAST_EOI;
            end
         end
         S_LAST_EOI: begin
            if (cmd_fire) begin
               started_in = 1'b0;
               state_in   = sweep_req_ff ? S_SWEEP : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         csr_ff       <= CSR_W'(8);
         prefix_ff    <= '0;
         nfc_ff       <= '0;
         thr_ff       <= '0;
         cw_ff        <= '0;
         started_ff   <= 1'b0;
         sweep_ff     <= '0;
         epoch_ff     <= EPOCH_W'(1);
         sweep_req_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         if (csr_ch.valid) begin
            csr_ff <= csr_ch.min_code_size;
         end
         prefix_ff    <= prefix_in;
         nfc_ff       <= nfc_in;
         thr_ff       <= thr_in;
         cw_ff        <= cw_in;
         started_ff   <= started_in;
         sweep_ff     <= sweep_in;
         epoch_ff     <= epoch_in;
         sweep_req_ff <= sweep_req_in;
      end
      px_ff   <= px_in;
      last_ff <= last_in;
      addr_ff <= addr_in;
   end

   // Single-port style dictionary memory with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

endmodule
